// ===== hdl/s2ig_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the strided 2-D index generator.
// No dependencies; imported by s2ig_next and strided_2d_index_generator.
package s2ig_pkg;

    localparam int unsigned ExtW   = 17;
    localparam int unsigned CoordW = 16;
    localparam int unsigned IdxW   = 32;
    localparam int unsigned RegIdxW = 3;

    typedef enum logic [RegIdxW-1:0] {
        REG_ROW_EXTENT = 3'd0,
        REG_COL_EXTENT = 3'd1,
        REG_ROW_FIRST  = 3'd2,
        REG_ROW_STEP   = 3'd3,
        REG_ROW_LAST   = 3'd4,
        REG_COL_FIRST  = 3'd5,
        REG_COL_STEP   = 3'd6,
        REG_COL_LAST   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [ExtW-1:0]   row_extent;
        logic [ExtW-1:0]   col_extent;
        logic [CoordW-1:0] row_first;
        logic [CoordW-1:0] row_step;
        logic [CoordW-1:0] row_last;
        logic [CoordW-1:0] col_first;
        logic [CoordW-1:0] col_step;
        logic [CoordW-1:0] col_last;
    } win_cfg_t;

    typedef struct packed {
        logic [CoordW-1:0] row;
        logic [CoordW-1:0] col;
        logic [IdxW-1:0]   base;
        logic              in_progress;
    } cursor_t;

    typedef struct packed {
        logic [IdxW-1:0] flat_index;
        logic            is_final;
        logic            bad_window;
    } result_t;

    localparam win_cfg_t CfgReset = '{
        row_extent: 17'd1,
        col_extent: 17'd1,
        row_first:  16'd0,
        row_step:   16'd1,
        row_last:   16'd0,
        col_first:  16'd0,
        col_step:   16'd1,
        col_last:   16'd0
    };

endpackage

// ===== hdl/s2ig_next.sv =====
`timescale 1ns / 1ps
// Next-element logic: window check, cursor advance and flat index.
// Depends on s2ig_pkg.
module s2ig_next #(
    parameter int unsigned MAX_EXTENT = 65536
) (
    input  s2ig_pkg::win_cfg_t cfg,
    input  s2ig_pkg::cursor_t  cur,
    input  logic               restart,
    output s2ig_pkg::cursor_t  nxt,
    output s2ig_pkg::result_t  res
);
    import s2ig_pkg::*;

    localparam logic [ExtW-1:0] MaxExt = ExtW'(MAX_EXTENT);

    logic                window_ok;
    logic [CoordW:0]     col_sum;
    logic [CoordW:0]     row_sum;
    logic [CoordW:0]     new_col_sum;
    logic [CoordW:0]     new_row_sum;
    logic [IdxW:0]       first_prod;
    logic [IdxW:0]       stride_prod;
    logic                is_final;

    always_comb begin
        window_ok = 1'b1;
        if (cfg.row_extent == '0 || cfg.row_extent > MaxExt) window_ok = 1'b0;
        if (cfg.col_extent == '0 || cfg.col_extent > MaxExt) window_ok = 1'b0;
        if (cfg.row_step == '0 || cfg.col_step == '0) window_ok = 1'b0;
        if (cfg.row_first > cfg.row_last || cfg.col_first > cfg.col_last) window_ok = 1'b0;
        if ({1'b0, cfg.row_last} >= cfg.row_extent) window_ok = 1'b0;
        if ({1'b0, cfg.col_last} >= cfg.col_extent) window_ok = 1'b0;
    end

    // both products depend on configuration only
    assign first_prod  = (IdxW+1)'(cfg.row_first * cfg.col_extent);
    assign stride_prod = (IdxW+1)'(cfg.row_step * cfg.col_extent);

    assign col_sum = {1'b0, cur.col} + {1'b0, cfg.col_step};
    assign row_sum = {1'b0, cur.row} + {1'b0, cfg.row_step};

    always_comb begin
        nxt = cur;
        if (!window_ok) begin
            nxt.in_progress = 1'b0;
        end else if (restart || !cur.in_progress) begin
            nxt.row  = cfg.row_first;
            nxt.col  = cfg.col_first;
            nxt.base = first_prod[IdxW-1:0];
        end else if (col_sum <= {1'b0, cfg.col_last}) begin
            nxt.col = col_sum[CoordW-1:0];
        end else begin
            // a row step only happens inside the window, so the base
            // can move by a fixed stride without a fresh multiply
            nxt.col  = cfg.col_first;
            nxt.row  = row_sum[CoordW-1:0];
            nxt.base = cur.base + stride_prod[IdxW-1:0];
        end

        new_col_sum = {1'b0, nxt.col} + {1'b0, cfg.col_step};
        new_row_sum = {1'b0, nxt.row} + {1'b0, cfg.row_step};
        is_final    = (new_col_sum > {1'b0, cfg.col_last})
                   && (new_row_sum > {1'b0, cfg.row_last});

        if (window_ok) begin
            nxt.in_progress = !is_final;
            res.flat_index  = nxt.base + {{(IdxW-CoordW){1'b0}}, nxt.col};
            res.is_final    = is_final;
            res.bad_window  = 1'b0;
        end else begin
            res.flat_index  = '0;
            res.is_final    = 1'b1;
            res.bad_window  = 1'b1;
        end
    end

endmodule

// ===== hdl/strided_2d_index_generator.sv =====
`timescale 1ns / 1ps
// Strided 2-D index generator. Each beat on the s_ channel asks for one
// element of a start:step:last window over a row-major array and returns
// one beat on the m_ channel with its flat index (row * col_extent + col),
// the column running fastest. The last element is flagged is_final and the
// following request wraps to the first; s_restart=1 always starts at the
// first element. An invalid window (zero step, first above last, last
// outside the extent, extent zero or above MAX_EXTENT) returns index 0 with
// is_final and bad_window set. Throughput is one index per clock while the
// receiver keeps m_ready high, and each result is registered in the cycle
// after its request is accepted: a single pass of add/compare logic plus a
// configuration-only multiply sits between the cursor state and the output
// register, and a new request is taken whenever the output register is empty
// or being drained. Any register write restarts the sequence; write only
// while no request is outstanding. Depends on s2ig_pkg and s2ig_next.
module strided_2d_index_generator #(
    parameter int unsigned MAX_EXTENT = 65536
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [s2ig_pkg::RegIdxW-1:0]       cfg_index,
    input  logic [s2ig_pkg::ExtW-1:0]          cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_restart,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [s2ig_pkg::IdxW-1:0]          m_flat_index,
    output logic                               m_is_final,
    output logic                               m_bad_window
);
    import s2ig_pkg::*;

    win_cfg_t cfg_reg;
    win_cfg_t cfg_next;
    cursor_t  cur_reg;
    cursor_t  cur_next;
    cursor_t  step_cur;
    result_t  step_res;
    result_t  res_reg;
    logic     m_valid_reg;
    logic     s_beat;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_beat  = s_valid && s_ready;

    s2ig_next #(
        .MAX_EXTENT(MAX_EXTENT)
    ) u_next (
        .cfg     (cfg_reg),
        .cur     (cur_reg),
        .restart (s_restart),
        .nxt     (step_cur),
        .res     (step_res)
    );

    always_comb begin
        cfg_next = cfg_reg;
        cur_next = cur_reg;
        if (s_beat) begin
            cur_next = step_cur;
        end
        if (cfg_wr_en) begin
            unique case (reg_idx_t'(cfg_index))
                REG_ROW_EXTENT: cfg_next.row_extent = cfg_wdata;
                REG_COL_EXTENT: cfg_next.col_extent = cfg_wdata;
                REG_ROW_FIRST:  cfg_next.row_first  = cfg_wdata[CoordW-1:0];
                REG_ROW_STEP:   cfg_next.row_step   = cfg_wdata[CoordW-1:0];
                REG_ROW_LAST:   cfg_next.row_last   = cfg_wdata[CoordW-1:0];
                REG_COL_FIRST:  cfg_next.col_first  = cfg_wdata[CoordW-1:0];
                REG_COL_STEP:   cfg_next.col_step   = cfg_wdata[CoordW-1:0];
                REG_COL_LAST:   cfg_next.col_last   = cfg_wdata[CoordW-1:0];
                default:        cfg_next = cfg_reg;
            endcase
            cur_next.in_progress = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg     <= CfgReset;
            cur_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
            cur_reg <= cur_next;
            if (s_beat) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            res_reg <= step_res;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_flat_index = res_reg.flat_index;
    assign m_is_final   = res_reg.is_final;
    assign m_bad_window = res_reg.bad_window;

`ifndef SYNTHESIS
    a_bad_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_window |-> m_is_final && m_flat_index == '0)
        else $error("bad window beat without final flag or zero index");

    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted request produced no result beat");

    a_final_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && step_res.is_final |=> !cur_reg.in_progress)
        else $error("sequence still running after final element");

    a_cfg_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> !cur_reg.in_progress)
        else $error("register write did not restart the sequence");
`endif

endmodule

// ===== test/s2ig_index_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the strided 2-D index generator: follows register writes and
// both beat channels, predicts each result and compares it. Depends on s2ig_pkg.
module s2ig_index_checker #(
    parameter int unsigned MAX_EXTENT = 65536
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [s2ig_pkg::RegIdxW-1:0] cfg_index,
    input  logic [s2ig_pkg::ExtW-1:0]    cfg_wdata,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic                         s_restart,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic [s2ig_pkg::IdxW-1:0]    m_flat_index,
    input  logic                         m_is_final,
    input  logic                         m_bad_window,
    output int                           failures,
    output int                           pending
);
    import s2ig_pkg::*;

    win_cfg_t win;
    cursor_t  cur;
    result_t  pending_indices[$];
    int       mismatch_count = 0;
    int       outstanding = 0;

    assign failures = mismatch_count;
    assign pending  = outstanding;

    task automatic log_mismatch(string what);
        if (mismatch_count < 100) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
        mismatch_count++;
    endtask

    function automatic bit window_valid();
        if (win.row_extent == 0 || win.row_extent > MAX_EXTENT) return 1'b0;
        if (win.col_extent == 0 || win.col_extent > MAX_EXTENT) return 1'b0;
        if (win.row_step == 0 || win.col_step == 0) return 1'b0;
        if (win.row_first > win.row_last || win.col_first > win.col_last) return 1'b0;
        if ({1'b0, win.row_last} >= win.row_extent) return 1'b0;
        if ({1'b0, win.col_last} >= win.col_extent) return 1'b0;
        return 1'b1;
    endfunction

    // Moves the cursor one element on and returns the index it lands on.
    function automatic result_t advance_window(logic restart);
        result_t          r;
        logic [CoordW:0]  col_next;
        logic [CoordW:0]  row_next;
        logic             last;
        if (!window_valid()) begin
            cur.in_progress = 1'b0;
            r.flat_index = '0;
            r.is_final   = 1'b1;
            r.bad_window = 1'b1;
            return r;
        end
        col_next = {1'b0, cur.col} + win.col_step;
        if (restart || !cur.in_progress) begin
            cur.row  = win.row_first;
            cur.col  = win.col_first;
            cur.base = IdxW'(win.row_first) * IdxW'(win.col_extent);
        end else if (col_next <= {1'b0, win.col_last}) begin
            cur.col = col_next[CoordW-1:0];
        end else begin
            cur.col  = win.col_first;
            cur.row  = cur.row + win.row_step;
            cur.base = IdxW'(cur.row) * IdxW'(win.col_extent);
        end
        col_next = {1'b0, cur.col} + win.col_step;
        row_next = {1'b0, cur.row} + win.row_step;
        last = (col_next > {1'b0, win.col_last}) && (row_next > {1'b0, win.row_last});
        cur.in_progress = !last;
        r.flat_index = cur.base + IdxW'(cur.col);
        r.is_final   = last;
        r.bad_window = 1'b0;
        return r;
    endfunction

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            win = CfgReset;
            cur = '0;
            pending_indices.delete();
        end else begin
            if (cfg_wr_en) begin
                case (reg_idx_t'(cfg_index))
                    REG_ROW_EXTENT: win.row_extent = cfg_wdata;
                    REG_COL_EXTENT: win.col_extent = cfg_wdata;
                    REG_ROW_FIRST:  win.row_first  = cfg_wdata[CoordW-1:0];
                    REG_ROW_STEP:   win.row_step   = cfg_wdata[CoordW-1:0];
                    REG_ROW_LAST:   win.row_last   = cfg_wdata[CoordW-1:0];
                    REG_COL_FIRST:  win.col_first  = cfg_wdata[CoordW-1:0];
                    REG_COL_STEP:   win.col_step   = cfg_wdata[CoordW-1:0];
                    default:        win.col_last   = cfg_wdata[CoordW-1:0];
                endcase
                cur.in_progress = 1'b0;
            end
            if (s_valid && s_ready) begin
                pending_indices.push_back(advance_window(s_restart));
            end
            if (m_valid && m_ready) begin
                if (pending_indices.size() == 0) begin
                    log_mismatch($sformatf("beat with nothing expected, index %0h",
                                           m_flat_index));
                end else begin
                    want = pending_indices.pop_front();
                    if (m_flat_index !== want.flat_index) begin
                        log_mismatch($sformatf("flat_index %0h, want %0h",
                                               m_flat_index, want.flat_index));
                    end
                    if (m_is_final !== want.is_final) begin
                        log_mismatch($sformatf("is_final %b, want %b (index %0h)",
                                               m_is_final, want.is_final, want.flat_index));
                    end
                    if (m_bad_window !== want.bad_window) begin
                        log_mismatch($sformatf("bad_window %b, want %b (index %0h)",
                                               m_bad_window, want.bad_window,
                                               want.flat_index));
                    end
                end
            end
        end
        outstanding = pending_indices.size();
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Top of the index generator bench: clock, reset, register writes, request
// beats and receiver stalls. Depends on s2ig_pkg and s2ig_index_checker.
module testbench;
    import s2ig_pkg::*;

    localparam int unsigned MaxExtent  = 65536;
    localparam int          CycleLimit = 200000;
    localparam int          RandomBeats = 650;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [RegIdxW-1:0] cfg_index;
    logic [ExtW-1:0]    cfg_wdata;
    logic               s_valid;
    logic               s_ready;
    logic               s_restart;
    logic               m_valid;
    logic               m_ready;
    logic [IdxW-1:0]    m_flat_index;
    logic               m_is_final;
    logic               m_bad_window;

    int       failures;
    int       pending;
    int       cycle_count = 0;
    int       send_pct = 0;
    int       recv_pct = 0;
    win_cfg_t cfg_now;

    strided_2d_index_generator dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_restart    (s_restart),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_flat_index (m_flat_index),
        .m_is_final   (m_is_final),
        .m_bad_window (m_bad_window)
    );

    s2ig_index_checker #(.MAX_EXTENT(MaxExtent)) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_restart    (s_restart),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_flat_index (m_flat_index),
        .m_is_final   (m_is_final),
        .m_bad_window (m_bad_window),
        .failures     (failures),
        .pending      (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CycleLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= (recv_pct == 0) || ($urandom_range(99) >= recv_pct);
    end

    function automatic win_cfg_t make_window(int unsigned re, int unsigned ce,
                                             int unsigned rf, int unsigned rs,
                                             int unsigned rl, int unsigned cf,
                                             int unsigned cs, int unsigned cl);
        win_cfg_t w;
        w.row_extent = ExtW'(re);
        w.col_extent = ExtW'(ce);
        w.row_first  = CoordW'(rf);
        w.row_step   = CoordW'(rs);
        w.row_last   = CoordW'(rl);
        w.col_first  = CoordW'(cf);
        w.col_step   = CoordW'(cs);
        w.col_last   = CoordW'(cl);
        return w;
    endfunction

    // Mostly small dense arrays so sequences wrap often; some corners of big
    // arrays, and now and then a window broken in one way.
    function automatic win_cfg_t random_window();
        win_cfg_t    w;
        int unsigned reach;
        if ($urandom_range(99) < 70) begin
            w.row_extent = ExtW'($urandom_range(1, 12));
            w.col_extent = ExtW'($urandom_range(1, 12));
            w.row_last   = CoordW'($urandom_range(0, w.row_extent - 1));
            w.row_first  = CoordW'($urandom_range(0, w.row_last));
            w.col_last   = CoordW'($urandom_range(0, w.col_extent - 1));
            w.col_first  = CoordW'($urandom_range(0, w.col_last));
            w.row_step   = CoordW'($urandom_range(1, 4));
            w.col_step   = CoordW'($urandom_range(1, 4));
        end else begin
            w.row_extent = ExtW'($urandom_range(1, MaxExtent));
            w.col_extent = ExtW'($urandom_range(1, MaxExtent));
            w.row_last   = CoordW'($urandom_range(0, w.row_extent - 1));
            w.col_last   = CoordW'($urandom_range(0, w.col_extent - 1));
            reach        = (w.row_last < 6) ? w.row_last : 6;
            w.row_first  = w.row_last - CoordW'($urandom_range(0, reach));
            reach        = (w.col_last < 6) ? w.col_last : 6;
            w.col_first  = w.col_last - CoordW'($urandom_range(0, reach));
            w.row_step   = ($urandom_range(3) == 0) ? 16'hFFFF : CoordW'($urandom_range(1, 3));
            w.col_step   = ($urandom_range(3) == 0) ? 16'hFFFF : CoordW'($urandom_range(1, 3));
        end
        if ($urandom_range(99) < 15) begin
            case ($urandom_range(7))
                0: w.row_step = '0;
                1: w.col_step = '0;
                2: begin
                    w.row_first = 16'hFFFF;
                    w.row_last  = CoordW'($urandom_range(0, 65534));
                end
                3: begin
                    w.col_first = 16'hFFFF;
                    w.col_last  = CoordW'($urandom_range(0, 65534));
                end
                4: w.row_extent = {1'b0, w.row_last};
                5: w.col_extent = {1'b0, w.col_last};
                6: if ($urandom_range(1)) w.row_extent = '0; else w.col_extent = '0;
                default: w.col_extent = ExtW'($urandom_range(MaxExtent + 1, 131071));
            endcase
        end
        return w;
    endfunction

    // Writes the registers picked by mask, one per cycle; bit 16 of the
    // 16-bit registers carries junk that the block must drop.
    task automatic load_window(win_cfg_t w, logic [7:0] mask);
        logic [ExtW-1:0] val;
        for (int i = 0; i < 8; i++) begin
            if (!mask[i]) continue;
            case (reg_idx_t'(i))
                REG_ROW_EXTENT: val = w.row_extent;
                REG_COL_EXTENT: val = w.col_extent;
                REG_ROW_FIRST:  val = {1'($urandom), w.row_first};
                REG_ROW_STEP:   val = {1'($urandom), w.row_step};
                REG_ROW_LAST:   val = {1'($urandom), w.row_last};
                REG_COL_FIRST:  val = {1'($urandom), w.col_first};
                REG_COL_STEP:   val = {1'($urandom), w.col_step};
                default:        val = {1'($urandom), w.col_last};
            endcase
            cfg_wr_en <= 1'b1;
            cfg_index <= reg_idx_t'(i);
            cfg_wdata <= val;
            @(negedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // One request beat; entered and left at a falling edge.
    task automatic push(bit restart);
        if (send_pct != 0 && $urandom_range(99) < send_pct) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < send_pct);
        end
        s_valid   <= 1'b1;
        s_restart <= restart;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
    endtask

    initial begin
        int random_beats;
        int phase;
        int beats;
        int pause_at;
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_ROW_EXTENT;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_restart = 1'b0;
        m_ready   = 1'b0;
        random_beats = 0;
        phase = 0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset window is a single element: always index 0, always final.
        push(1'b0);
        push(1'b1);

        // Bottom-right corner of the largest array: indices up to all ones,
        // then wrap, then a restart mid-sequence.
        drain();
        load_window(make_window(65536, 65536, 65534, 1, 65535, 65534, 1, 65535), 8'hFF);
        repeat (5) push(1'b0);
        push(1'b1);
        push(1'b0);

        // Largest strides: the step sum overflows 16 bits.
        drain();
        load_window(make_window(65536, 65536, 0, 65535, 65535, 0, 65535, 65535), 8'hFF);
        repeat (4) push(1'b0);

        // Invalid windows, one request each.
        drain();
        load_window(make_window(4, 4, 0, 0, 3, 0, 1, 3), 8'hFF);
        push(1'b0);
        drain();
        load_window(make_window(4, 4, 0, 1, 3, 0, 0, 3), 8'hFF);
        push(1'b1);
        drain();
        load_window(make_window(4, 4, 3, 1, 2, 0, 1, 3), 8'hFF);
        push(1'b0);
        drain();
        load_window(make_window(4, 4, 0, 1, 3, 2, 1, 1), 8'hFF);
        push(1'b0);
        drain();
        load_window(make_window(4, 4, 0, 1, 4, 0, 1, 3), 8'hFF);
        push(1'b0);
        drain();
        load_window(make_window(4, 4, 0, 1, 3, 0, 1, 4), 8'hFF);
        push(1'b0);
        drain();
        load_window(make_window(0, 4, 0, 1, 0, 0, 1, 3), 8'hFF);
        push(1'b0);
        drain();
        load_window(make_window(4, 131071, 0, 1, 3, 0, 1, 3), 8'hFF);
        push(1'b0);
        drain();
        load_window(make_window(65537, 4, 0, 1, 3, 0, 1, 3), 8'hFF);
        push(1'b0);

        while (random_beats < RandomBeats) begin
            drain();
            case (phase % 5)
                0, 4: begin send_pct = 0;  recv_pct = 0;  end
                1:    begin send_pct = 64; recv_pct = 0;  end
                2:    begin send_pct = 0;  recv_pct = 64; end
                default: begin send_pct = 27; recv_pct = 27; end
            endcase
            phase++;
            cfg_now = random_window();
            load_window(cfg_now, 8'hFF);
            beats    = $urandom_range(15, 50);
            pause_at = $urandom_range(0, beats - 1);
            for (int i = 0; i < beats; i++) begin
                // Let the pipe run dry mid-sequence; a rewrite of one register
                // with its own value must still send the cursor back to the start.
                if (i == pause_at) begin
                    drain();
                    if ($urandom_range(1)) begin
                        load_window(cfg_now, 8'(1 << $urandom_range(7)));
                    end
                end
                push($urandom_range(99) < 8);
                random_beats++;
            end
        end

        drain();
        repeat (8) @(negedge aclk);
        if (failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/s2ig_pkg.sv
hdl/s2ig_next.sv
hdl/strided_2d_index_generator.sv
test/s2ig_index_checker.sv
test/testbench.sv
